/* hw/rtl/pwt_pkg.sv */
// Package for the port whitelist table: payload structs, status codes, constants.
// No dependencies.
`default_nettype none
package pwt_pkg;

    localparam logic [31:0] LOOPBACK_ADDR = 32'h0100007F;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [1:0] PROTO_TCP = 2'd0;
    localparam logic [1:0] PROTO_UDP = 2'd1;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_REMOVED = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;
    localparam logic [2:0] ST_READ    = 3'd7;

    localparam logic [0:0] REG_FILTER_ENABLE = 1'd0;
    localparam logic [0:0] REG_USB_CONNECTED = 1'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  protocol;
        logic [31:0] src_addr;
        logic [15:0] port;
        logic        connected;
        logic [6:0]  slot;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] read_data;
        logic [8:0]  tcp_entries;
        logic [8:0]  udp_entries;
    } rsp_beat_t;

endpackage
`default_nettype wire

/* hw/rtl/port_whitelist_table.sv */
// Port whitelist table top level: APB registers, command sequencer, two list memories.
// Depends on pwt_pkg and pwt_list_mem.
//
// Usage:
//   Command channel: drive cmd and pulse start while busy is low; the beat is
//   taken at that edge and busy stays high through the cycle that shows the result.
//   Result channel: rsp is valid for exactly one cycle while done is high; the
//   receiver cannot stall it.
//   Steps: a read passes through S_READ and S_DONE. Add and remove scan the
//   selected list one entry per cycle through the single read port of its
//   memory; a remove then shifts each later entry down one place, each shift
//   a read (S_SHIFT_RD) followed by a write (S_SHIFT_WR). One command is
//   worked at a time.
//   Reset clears both counts and the registers (filter_enable=1,
//   usb_connected=0); list contents are undefined but never used past count.
//   Configuration may be written at any time over APB; write only while idle.
`default_nettype none
module port_whitelist_table
    import pwt_pkg::*;
#(
    parameter int STORE_DEPTH = 256,
    parameter int TABLE_SLOTS = 127
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    input  wire logic      start,
    input  wire cmd_beat_t cmd,
    output logic           busy,
    output logic           done,
    output rsp_beat_t      rsp
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_READ, S_DONE} state_t;

    state_t      state_reg;
    logic        fen_reg, usb_reg;
    cmd_beat_t   cmd_reg;
    logic [CW-1:0] tcnt_reg, ucnt_reg;
    logic [CW-1:0] idx_reg;
    logic        pend_reg;
    logic [2:0]  status_reg;
    logic [15:0] data_reg;
    logic        done_reg;

    logic        sel_tcp;
    logic [CW-1:0] cnt;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata, rd_t, rd_u, rd;
    logic        is_loop;

    assign pready = 1'b1;
    assign prdata = {31'd0, (paddr[2] == REG_USB_CONNECTED) ? usb_reg : fen_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fen_reg <= 1'b1;
            usb_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_FILTER_ENABLE)
                fen_reg <= pwdata[0];
            else
                usb_reg <= pwdata[0];
        end
    end

    assign sel_tcp = (cmd_reg.protocol == PROTO_TCP);
    assign cnt     = sel_tcp ? tcnt_reg : ucnt_reg;
    assign rd      = sel_tcp ? rd_t : rd_u;
    assign is_loop = (cmd.src_addr == LOOPBACK_ADDR);

    always_comb
    begin
        raddr = idx_reg[AW-1:0];
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rd;
        case (state_reg)
            S_IDLE:
            begin
                raddr = AW'(cmd.slot - 7'd1);
            end
            S_SHIFT_WR:
            begin
                we    = 1'b1;
                waddr = AW'(idx_reg - CW'(1));
            end
            S_DONE:
            begin
                we    = pend_reg;
                waddr = cnt[AW-1:0];
                wdata = cmd_reg.port;
            end
            default: ;
        endcase
    end

    pwt_list_mem #(.DEPTH(STORE_DEPTH), .AW(AW)) u_tcp (
        .clk(clk), .we(we && sel_tcp), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd_t));
    pwt_list_mem #(.DEPTH(STORE_DEPTH), .AW(AW)) u_udp (
        .clk(clk), .we(we && !sel_tcp), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd_u));

    // scan: idx_reg is the address in flight; pend_reg marks its data valid next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tcnt_reg  <= '0;
            ucnt_reg  <= '0;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        cmd_reg  <= cmd;
                        data_reg <= '0;
                        idx_reg  <= '0;
                        pend_reg <= 1'b0;
                        status_reg <= ST_IGNORED;
                        if (cmd.command == CMD_READ)
                        begin
                            if (cmd.protocol == PROTO_TCP || cmd.protocol == PROTO_UDP)
                            begin
                                status_reg <= ST_READ;
                                idx_reg    <= CW'(cmd.slot) - CW'(1);
                                state_reg  <= S_READ;
                            end
                            else
                                state_reg <= S_DONE;
                        end
                        else if ((cmd.command == CMD_ADD || cmd.command == CMD_REMOVE)
                                 && fen_reg)
                        begin
                            if (cmd.protocol == PROTO_TCP && cmd.command == CMD_REMOVE
                                && !is_loop && cmd.connected)
                            begin
                                status_reg <= ST_REFUSED;
                                state_reg  <= S_DONE;
                            end
                            else if (!is_loop && cmd.port != 16'd0
                                     && (cmd.protocol == PROTO_TCP
                                         || cmd.protocol == PROTO_UDP))
                                state_reg <= S_SCAN;
                            else
                                state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_DONE;
                    if (cmd_reg.slot == 7'd0)
                        data_reg <= {15'd0, fen_reg && !usb_reg
                                     && cnt <= CW'(TABLE_SLOTS)};
                    else if (32'(cmd_reg.slot) <= 32'(TABLE_SLOTS)
                             && CW'(cmd_reg.slot) <= cnt)
                        data_reg <= rd;
                end
                S_SCAN:
                begin
                    if (pend_reg && rd == cmd_reg.port)
                    begin
                        pend_reg <= 1'b0;
                        if (cmd_reg.command == CMD_ADD)
                        begin
                            status_reg <= ST_PRESENT;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            status_reg <= ST_REMOVED;
                            state_reg  <= S_SHIFT_RD;
                        end
                    end
                    else if (idx_reg >= cnt)
                    begin
                        pend_reg <= 1'b0;
                        if (cmd_reg.command == CMD_REMOVE)
                            status_reg <= ST_ABSENT;
                        else if (cnt == CW'(STORE_DEPTH))
                            status_reg <= ST_FULL;
                        else
                        begin
                            status_reg <= ST_ADDED;
                            pend_reg   <= 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                        idx_reg  <= idx_reg + CW'(1);
                    end
                end
                S_SHIFT_RD:
                begin
                    // idx_reg is one past the match; read it and write it one lower
                    if (idx_reg >= cnt)
                    begin
                        if (sel_tcp) tcnt_reg <= tcnt_reg - CW'(1);
                        else         ucnt_reg <= ucnt_reg - CW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR:
                begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_DONE:
                begin
                    if (pend_reg)
                    begin
                        if (sel_tcp) tcnt_reg <= tcnt_reg + CW'(1);
                        else         ucnt_reg <= ucnt_reg + CW'(1);
                    end
                    pend_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    always_comb
    begin
        rsp.status      = status_reg;
        rsp.read_data   = data_reg;
        rsp.tcp_entries = 9'(tcnt_reg);
        rsp.udp_entries = 9'(ucnt_reg);
    end
endmodule
`default_nettype wire

/* hw/rtl/pwt_list_mem.sv */
// One port list memory: one synchronous write port, one synchronous read port.
// Uses no package.
`default_nettype none
module pwt_list_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);
    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/pwt_checker.sv */
// Port-level checks for the port whitelist table, bound to the top level.
// Depends on pwt_pkg.
`default_nettype none
module pwt_checker
    import pwt_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      done,
    input wire rsp_beat_t rsp
);
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_read_nz: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_READ |-> rsp.read_data == 16'd0)
        else $error("read_data nonzero");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(done) == 1'b0 && rsp.status == ST_ADDED
        |-> rsp.tcp_entries != 9'd0 || rsp.udp_entries != 9'd0)
        else $error("add with empty lists");
endmodule

bind port_whitelist_table pwt_checker u_pwt_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp));
`default_nettype wire
